[hdl/aqs_pkg.sv]
// Shared types and constants for the air quality score block.
// No dependencies; every other file of the block imports this package.
package aqs_pkg;

	// Field widths of the sensor readings and of the results.
	localparam int unsigned HUM_W   = 7;
	localparam int unsigned RAW_W   = 16;
	localparam int unsigned SCORE_W = 7;
	localparam int unsigned DUTY_W  = 8;
	localparam int unsigned CFG_W   = 64;
	localparam int unsigned IDX_W   = 2;

	// Divider geometry: 100 * distance fits 23 bits, the rank fits 7 bits.
	localparam int unsigned NUM_W   = 23;
	localparam int unsigned QUO_W   = 7;

	// Pipeline depth: one classify stage, one stage per quotient bit, four merge stages.
	localparam int unsigned LANE_DEPTH  = 1 + QUO_W;
	localparam int unsigned MERGE_DEPTH = 4;
	localparam int unsigned PIPE_DEPTH  = LANE_DEPTH + MERGE_DEPTH;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_HUMIDITY = 2'd0;
	localparam logic [IDX_W-1:0] REG_PRESSURE = 2'd1;
	localparam logic [IDX_W-1:0] REG_CO2      = 2'd2;

	// Arithmetic constants.
	localparam logic [SCORE_W-1:0] FULL_SCORE = 7'd100;
	localparam logic [6:0]         PCT_MUL    = 7'd100;
	localparam logic [7:0]         DUTY_MUL   = 8'd255;
	// floor(s / 3) = (s * 683) >> 11 for every sum of three scores.
	localparam logic [9:0]         RECIP3     = 10'd683;
	localparam int unsigned        RECIP3_SH  = 11;
	// floor(x / 100) = (x * 5243) >> 19 for every x up to 255 * 100.
	localparam logic [12:0]        RECIP100   = 13'd5243;
	localparam int unsigned        RECIP100_SH = 19;

	// One limits register, packed as in the register map.
	typedef struct packed {
		logic [RAW_W-1:0] urgent_max;
		logic [RAW_W-1:0] warn_max;
		logic [RAW_W-1:0] urgent_min;
		logic [RAW_W-1:0] warn_min;
	} aqs_limits_t;

	// The three scores handed from the lanes to the merge stage.
	typedef struct packed {
		logic [SCORE_W-1:0] hum;
		logic [SCORE_W-1:0] pres;
		logic [SCORE_W-1:0] co2;
	} aqs_scores_t;

endpackage

[hdl/aqs_if.sv]
// Valid/ready channel interfaces for sensor sets and for results.
// Depends on aqs_pkg for the field widths.
interface aqs_in_if;
	import aqs_pkg::*;
	logic               valid;
	logic               ready;
	logic [HUM_W-1:0]   humidity;
	logic [RAW_W-1:0]   pressure;
	logic [RAW_W-1:0]   co2_ppm;

	modport source (output valid, output humidity, output pressure, output co2_ppm,
		input ready);
	modport sink (input valid, input humidity, input pressure, input co2_ppm,
		output ready);
endinterface

interface aqs_out_if;
	import aqs_pkg::*;
	logic               valid;
	logic               ready;
	logic [SCORE_W-1:0] humidity_score;
	logic [SCORE_W-1:0] pressure_score;
	logic [SCORE_W-1:0] co2_score;
	logic [SCORE_W-1:0] quality_score;
	logic [DUTY_W-1:0]  green_duty;
	logic [DUTY_W-1:0]  red_duty;

	modport source (output valid, output humidity_score, output pressure_score,
		output co2_score, output quality_score, output green_duty, output red_duty,
		input ready);
	modport sink (input valid, input humidity_score, input pressure_score,
		input co2_score, input quality_score, input green_duty, input red_duty,
		output ready);
endinterface

[hdl/aqs_lane.sv]
// One ranking lane: classifies a reading against its limits, then divides
// 100 * distance by the span one quotient bit per stage. Depends on aqs_pkg.
module aqs_lane (
	input  logic                 clk,
	input  logic                 adv,
	input  logic [15:0]          value,
	input  aqs_pkg::aqs_limits_t limits,
	output logic [6:0]           score
);
	import aqs_pkg::*;

	logic             is_urgent;
	logic             in_band;
	logic             low_side;
	logic [RAW_W-1:0] delta;
	logic [RAW_W-1:0] span;
	logic             no_div;

	// Stage registers, indexed by stage number (1 = classify).
	logic [NUM_W-1:0] rem_s  [1:LANE_DEPTH];
	logic [QUO_W-1:0] quo_s  [1:LANE_DEPTH];
	logic [RAW_W-1:0] span_s [1:LANE_DEPTH];
	logic             full_s [1:LANE_DEPTH];

	// Classification in the order urgent test, warning band, side selection.
	always_comb begin
		is_urgent = (value <= limits.urgent_min) || (value >= limits.urgent_max);
		in_band   = (value > limits.warn_min) && (value < limits.warn_max);
		low_side  = (value <= limits.warn_min);
		if (low_side) begin
			delta = limits.warn_min - value;
			span  = limits.warn_min - limits.urgent_min;
		end else begin
			delta = value - limits.warn_max;
			span  = limits.urgent_max - limits.warn_max;
		end
		no_div = (span == '0) || (delta >= span);
	end

	// Stage 1: register the numerator; inside the band it is zero so the rank is zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			full_s[1] <= is_urgent || (!in_band && no_div);
			rem_s[1]  <= in_band ? '0 : NUM_W'(delta * PCT_MUL);
			span_s[1] <= span;
			quo_s[1]  <= '0;
		end
	end

	// Restoring division, most significant quotient bit first.
	for (genvar st = 2; st <= LANE_DEPTH; st++) begin : g_div
		localparam int unsigned BIT = LANE_DEPTH - st;
		logic [NUM_W-1:0] shifted;
		logic             take;

		assign shifted = {{(NUM_W-RAW_W){1'b0}}, span_s[st-1]} << BIT;
		assign take    = (rem_s[st-1] >= shifted);

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[st]  <= take ? (rem_s[st-1] - shifted) : rem_s[st-1];
				quo_s[st]  <= quo_s[st-1] | (take ? (QUO_W'(1) << BIT) : '0);
				span_s[st] <= span_s[st-1];
				full_s[st] <= full_s[st-1];
			end
		end
	end

	// Score is zero for an urgent reading or when no division applies, else 100 minus the rank.
	assign score = full_s[LANE_DEPTH] ? '0 : (FULL_SCORE - quo_s[LANE_DEPTH]);

endmodule

[hdl/aqs_merge.sv]
// Merge stage: averages the three lane scores and derives the indicator duties
// through reciprocal multiplications over four stages. Depends on aqs_pkg.
module aqs_merge (
	input  logic                 clk,
	input  logic                 adv,
	input  aqs_pkg::aqs_scores_t scores,
	output aqs_pkg::aqs_scores_t scores_out,
	output logic [6:0]           quality,
	output logic [7:0]           green,
	output logic [7:0]           red
);
	import aqs_pkg::*;

	aqs_scores_t          sc_s1, sc_s2, sc_s3, sc_s4;
	logic [8:0]           sum_s1;
	logic [SCORE_W-1:0]   q_s2, q_s3, q_s4;
	logic [14:0]          gprod_s3, rprod_s3;
	logic [DUTY_W-1:0]    green_s4, red_s4;
	logic [18:0]          qprod;
	logic [27:0]          gq, rq;

	assign qprod = sum_s1 * RECIP3;
	assign gq    = gprod_s3 * RECIP100;
	assign rq    = rprod_s3 * RECIP100;

	// Stage 1: sum; stage 2: divide by three; stage 3: scale by 255; stage 4: divide by 100.
	always_ff @(posedge clk) begin
		if (adv) begin
			sc_s1    <= scores;
			sum_s1   <= 9'(scores.hum) + 9'(scores.pres) + 9'(scores.co2);
			sc_s2    <= sc_s1;
			q_s2     <= qprod[RECIP3_SH +: SCORE_W];
			sc_s3    <= sc_s2;
			q_s3     <= q_s2;
			gprod_s3 <= q_s2 * DUTY_MUL;
			rprod_s3 <= (FULL_SCORE - q_s2) * DUTY_MUL;
			sc_s4    <= sc_s3;
			q_s4     <= q_s3;
			green_s4 <= gq[RECIP100_SH +: DUTY_W];
			red_s4   <= rq[RECIP100_SH +: DUTY_W];
		end
	end

	assign scores_out = sc_s4;
	assign quality    = q_s4;
	assign green      = green_s4;
	assign red        = red_s4;

endmodule

[hdl/air_quality_score.sv]
// Top level of the air quality score block: configuration registers, input skid
// stage, three ranking lanes and the merge stage. Depends on aqs_pkg, aqs_if,
// aqs_lane and aqs_merge.
//
// The block accepts one sensor set per clock cycle while the pipeline advances and
// returns one result per set, in order: one classify stage and seven divider stages
// (one quotient bit each) in every lane, then four merge stages. The whole pipeline
// advances whenever the output register is empty or being taken; a one-entry skid
// register on the input keeps the input ready from depending on the output ready.
// Limits are to be written through cfg_we, cfg_idx and cfg_data only while the
// block is idle; the user ensures this, the block does not. Index 3 is ignored.
module air_quality_score (
	input  logic                       clk,
	input  logic                       arst_n,
	aqs_in_if.sink                     sensor,
	aqs_out_if.source                  result,
	input  logic                       cfg_we,
	input  logic [aqs_pkg::IDX_W-1:0]  cfg_idx,
	input  logic [aqs_pkg::CFG_W-1:0]  cfg_data
);
	import aqs_pkg::*;

	aqs_limits_t         hum_lim_q, pres_lim_q, co2_lim_q;
	logic                skid_full_q;
	logic [HUM_W-1:0]    skid_hum_q;
	logic [RAW_W-1:0]    skid_pres_q, skid_co2_q;
	logic [PIPE_DEPTH-1:0] vld_q;

	logic                adv;
	logic                src_valid;
	logic [HUM_W-1:0]    src_hum;
	logic [RAW_W-1:0]    src_pres, src_co2;
	aqs_scores_t         lane_scores, out_scores;
	logic [SCORE_W-1:0]  quality;
	logic [DUTY_W-1:0]   green, red;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hum_lim_q  <= '0;
			pres_lim_q <= '0;
			co2_lim_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HUMIDITY: hum_lim_q  <= cfg_data;
				REG_PRESSURE: pres_lim_q <= cfg_data;
				REG_CO2:      co2_lim_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline moves when the output register is free or being drained.
	assign adv          = !vld_q[PIPE_DEPTH-1] || result.ready;
	assign sensor.ready = !skid_full_q;
	assign src_valid    = skid_full_q || sensor.valid;
	assign src_hum      = skid_full_q ? skid_hum_q  : sensor.humidity;
	assign src_pres     = skid_full_q ? skid_pres_q : sensor.pressure;
	assign src_co2      = skid_full_q ? skid_co2_q  : sensor.co2_ppm;

	// Skid register holds a transaction that arrived while the pipeline was stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (adv) begin
			skid_full_q <= 1'b0;
		end else begin
			skid_full_q <= skid_full_q || sensor.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			skid_hum_q  <= sensor.humidity;
			skid_pres_q <= sensor.pressure;
			skid_co2_q  <= sensor.co2_ppm;
		end
	end

	// Valid bits travel alongside the lane and merge stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], src_valid};
		end
	end

	// Three ranking lanes.
	aqs_lane u_lane_hum (
		.clk    (clk),
		.adv    (adv),
		.value  ({{(RAW_W-HUM_W){1'b0}}, src_hum}),
		.limits (hum_lim_q),
		.score  (lane_scores.hum)
	);

	aqs_lane u_lane_pres (
		.clk    (clk),
		.adv    (adv),
		.value  (src_pres),
		.limits (pres_lim_q),
		.score  (lane_scores.pres)
	);

	aqs_lane u_lane_co2 (
		.clk    (clk),
		.adv    (adv),
		.value  (src_co2),
		.limits (co2_lim_q),
		.score  (lane_scores.co2)
	);

	// Quality and duty computation; its last stage is the output register.
	aqs_merge u_merge (
		.clk        (clk),
		.adv        (adv),
		.scores     (lane_scores),
		.scores_out (out_scores),
		.quality    (quality),
		.green      (green),
		.red        (red)
	);

	assign result.valid          = vld_q[PIPE_DEPTH-1];
	assign result.humidity_score = out_scores.hum;
	assign result.pressure_score = out_scores.pres;
	assign result.co2_score      = out_scores.co2;
	assign result.quality_score  = quality;
	assign result.green_duty     = green;
	assign result.red_duty       = red;

endmodule
